/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/ffsd_pkg.sv */
// ----------------------------------------------------------------------------
// ffsd_pkg
// Types and constants of the fire field stencil and decay filter.
// ----------------------------------------------------------------------------
package ffsd_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 8;
  localparam int LW_W       = 9;
  localparam int FR_W       = 11;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LINE_WIDTH = 1'd0;
  localparam cfg_idx_t REG_FRAME_ROWS = 1'd1;

  localparam logic [LW_W-1:0] WIDTH_RESET = 9'd170;
  localparam logic [FR_W-1:0] ROWS_RESET  = 11'd103;
  localparam int              WIDTH_MIN   = 4;
  localparam logic [FR_W-1:0] ROWS_MIN    = 11'd4;
  localparam logic [FR_W-1:0] ROWS_MAX    = 11'd1024;

  // First row whose pixels complete a stencil, and the lag to the target row.
  localparam logic [ROW_W-1:0] ROW_LAG = 10'd3;

  localparam logic [PIX_W-1:0] DECAY_HIGH = 8'd128;
  localparam logic [PIX_W-1:0] DECAY_MID  = 8'd12;
  localparam logic [PIX_W-1:0] DECAY_LOW  = 8'd8;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD_LEFT,
    ST_LOAD_MID,
    ST_LOAD_RIGHT
  } fetch_state_t;

  // One completed stencil, handed from the line control to the output stage.
  typedef struct packed {
    logic             push;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] below;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tap_t;

endpackage

/* hw/rtl/ffsd_ram.sv */
// ----------------------------------------------------------------------------
// ffsd_ram
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/ffsd_ctrl.sv */
// ----------------------------------------------------------------------------
// ffsd_ctrl
// Raster counters, line memory access, stencil window and reload sequencer.
// ----------------------------------------------------------------------------
module ffsd_ctrl #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [ffsd_pkg::PIX_W-1:0]         pixel_value,
  input  logic                               frame_start,
  input  logic                               cfg_valid,
  input  logic [ffsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffsd_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               skid_full,
  output logic                               ram_wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]       ram_wr_addr,
  output logic [2*ffsd_pkg::PIX_W-1:0]       ram_wr_data,
  output logic                               ram_rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]       ram_rd_addr,
  input  logic [2*ffsd_pkg::PIX_W-1:0]       ram_rd_data,
  output ffsd_pkg::tap_t                     tap
);

  import ffsd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;
  localparam int CW = (WW > LW_W) ? WW : LW_W;

  logic [LW_W-1:0]       line_width;
  logic [FR_W-1:0]       frame_rows;
  logic [AW-1:0]         column_count;
  logic [ROW_W-1:0]      row_count;
  logic [AW-1:0]         pc;
  logic                  win_valid;
  logic [2*PIX_W-1:0]    win_mid;
  logic [PIX_W-1:0]      win_left;
  fetch_state_t          state, state_next;

  logic [CW-1:0]         lw_ext;
  logic [WW-1:0]         width;
  logic [FR_W-1:0]       rows;
  logic [AW-1:0]         cbase;
  logic [AW-1:0]         col;
  logic [ROW_W-1:0]      row;
  logic [WW-1:0]         col_inc;
  logic [WW-1:0]         col_p2;
  logic [AW-1:0]         col_next;
  logic [AW-1:0]         col_ahead;
  logic [AW-1:0]         col_back;
  logic                  wrap;
  logic                  hit;
  logic                  accept;
  logic                  emit;
  logic                  load_left, load_mid, load_right;

  always_comb begin
    lw_ext = CW'(line_width);
    if (lw_ext < CW'(WIDTH_MIN)) begin
      width = WW'(WIDTH_MIN);
    end else if (lw_ext > CW'(MAX_WIDTH)) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = WW'(lw_ext);
    end
    if (frame_rows < ROWS_MIN) begin
      rows = ROWS_MIN;
    end else if (frame_rows > ROWS_MAX) begin
      rows = ROWS_MAX;
    end else begin
      rows = frame_rows;
    end
  end

  always_comb begin
    cbase     = frame_start ? '0 : column_count;
    row       = frame_start ? '0 : row_count;
    col       = (WW'(cbase) >= width) ? '0 : cbase;
    col_inc   = WW'(col) + WW'(1);
    wrap      = (col_inc >= width);
    col_next  = wrap ? '0 : AW'(col_inc);
    col_p2    = WW'(col) + WW'(2);
    col_ahead = (col_p2 >= width) ? AW'(col_p2 - width) : AW'(col_p2);
    col_back  = (col == '0) ? '0 : col - AW'(1);
    hit       = win_valid && (col == pc);
    emit      = (row >= ROW_LAG) && ({1'b0, row} < rows) && (col != '0)
                && ((WW+1)'(col) + (WW+1)'(3) <= (WW+1)'(width));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN:        if (in_valid && !hit) state_next = ST_LOAD_LEFT;
      ST_LOAD_LEFT:  state_next = ST_LOAD_MID;
      ST_LOAD_MID:   state_next = ST_LOAD_RIGHT;
      ST_LOAD_RIGHT: state_next = ST_RUN;
      default:       state_next = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = col_ahead;
    load_left   = 1'b0;
    load_mid    = 1'b0;
    load_right  = 1'b0;
    case (state)
      ST_RUN: begin
        in_ready  = hit && !skid_full;
        ram_rd_en = in_valid && in_ready;
      end
      ST_LOAD_LEFT: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = col_back;
      end
      ST_LOAD_MID: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = col;
        load_left   = 1'b1;
      end
      ST_LOAD_RIGHT: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = col_next;
        load_mid    = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    load_right = load_mid;
  end

  assign accept      = in_valid && in_ready;
  assign ram_wr_en   = accept;
  assign ram_wr_addr = col;
  assign ram_wr_data = {win_mid[PIX_W-1:0], pixel_value};

  always_comb begin
    tap.push  = accept && emit;
    tap.left  = win_left;
    tap.mid   = win_mid[PIX_W-1:0];
    tap.right = ram_rd_data[PIX_W-1:0];
    tap.above = win_mid[2*PIX_W-1:PIX_W];
    tap.below = pixel_value;
    tap.row   = row - ROW_LAG;
    tap.col   = COL_W'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RUN;
      line_width   <= WIDTH_RESET;
      frame_rows   <= ROWS_RESET;
      column_count <= '0;
      row_count    <= '0;
      pc           <= '0;
      win_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        column_count <= col_next;
        pc           <= col_next;
        if (wrap) begin
          row_count <= row + ROW_W'(1);
        end else begin
          row_count <= row;
        end
      end
      if (load_right) begin
        pc <= col;
      end
      if (cfg_valid) begin
        win_valid <= 1'b0;
        case (cfg_index)
          REG_LINE_WIDTH: line_width <= cfg_data[LW_W-1:0];
          REG_FRAME_ROWS: frame_rows <= cfg_data[FR_W-1:0];
          default:        line_width <= line_width;
        endcase
      end else if (load_right) begin
        win_valid <= 1'b1;
      end
    end
  end

  // Slide the window on a request, or reload it after a jump, a register write or reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      win_left <= win_mid[PIX_W-1:0];
      win_mid  <= ram_rd_data;
    end
    if (load_left) begin
      win_left <= ram_rd_data[2*PIX_W-1:PIX_W];
    end
    if (load_mid) begin
      win_mid <= ram_rd_data;
    end
  end

endmodule

/* hw/rtl/ffsd_out.sv */
// ----------------------------------------------------------------------------
// ffsd_out
// Stencil average, decay and two-entry result buffer.
// ----------------------------------------------------------------------------
module ffsd_out (
  input  logic                       clk,
  input  logic                       rst,
  input  ffsd_pkg::tap_t             tap,
  output logic                       skid_full,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ffsd_pkg::ROW_W-1:0] out_row,
  output logic [ffsd_pkg::COL_W-1:0] out_col,
  output logic [ffsd_pkg::PIX_W-1:0] heat_value
);

  import ffsd_pkg::*;

  logic [PIX_W+1:0]  sum4;
  logic [PIX_W:0]    sum2;
  logic [PIX_W-1:0]  avg;
  logic [PIX_W-1:0]  heat;

  logic                  head_v, skid_v;
  logic [ROW_W-1:0]      skid_row;
  logic [COL_W-1:0]      skid_col;
  logic [PIX_W-1:0]      skid_heat;
  logic                  pop;

  always_comb begin
    sum4 = (PIX_W+2)'(tap.left) + (PIX_W+2)'(tap.mid)
         + (PIX_W+2)'(tap.right) + (PIX_W+2)'(tap.below);
    sum2 = (PIX_W+1)'(sum4[PIX_W+1:2]) + (PIX_W+1)'(tap.above);
    avg  = sum2[PIX_W:1];
    if (avg > DECAY_HIGH) begin
      heat = avg - PIX_W'(2);
    end else if (avg > DECAY_MID) begin
      heat = avg - PIX_W'(4);
    end else if (avg > DECAY_LOW) begin
      heat = avg - PIX_W'(2);
    end else if (avg != '0) begin
      heat = avg - PIX_W'(1);
    end else begin
      heat = '0;
    end
  end

  assign pop       = head_v && out_ready;
  assign out_valid = head_v;
  assign skid_full = skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (pop) begin
        head_v <= skid_v || tap.push;
        skid_v <= 1'b0;
      end else if (tap.push) begin
        head_v <= 1'b1;
        skid_v <= head_v;
      end
    end
  end

  // Hold the head while stalled; park a new result in the skid slot.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v) begin
        out_row    <= skid_row;
        out_col    <= skid_col;
        heat_value <= skid_heat;
      end else begin
        out_row    <= tap.row;
        out_col    <= tap.col;
        heat_value <= heat;
      end
    end else if (tap.push) begin
      if (head_v) begin
        skid_row  <= tap.row;
        skid_col  <= tap.col;
        skid_heat <= heat;
      end else begin
        out_row    <= tap.row;
        out_col    <= tap.col;
        heat_value <= heat;
      end
    end
  end

endmodule

/* hw/rtl/fire_field_stencil_decay.sv */
// ----------------------------------------------------------------------------
// fire_field_stencil_decay
// Fire field averaging stencil with decay over a raster pixel stream.
//
//   channel   handshake                 payload
//   pixel     in_valid / in_ready       pixel_value, frame_start
//   result    out_valid / out_ready     out_row, out_col, heat_value
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One pixel per cycle unless the window reloads or the result buffer is full;
// the line memory is read two columns ahead of the pixel. A result is registered
// as its pixel is accepted. After a raster jump (frame start off column zero) or
// a register write, pixels stall while the window reloads from memory. Reset
// clears counters and result buffer, sets registers to defaults; line memory holds
// no reset. A stalled result sink fills a two-entry buffer, then backpressures pixels.
// ----------------------------------------------------------------------------
module fire_field_stencil_decay #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ffsd_pkg::PIX_W-1:0]          pixel_value,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ffsd_pkg::ROW_W-1:0]          out_row,
  output logic [ffsd_pkg::COL_W-1:0]          out_col,
  output logic [ffsd_pkg::PIX_W-1:0]          heat_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffsd_pkg::CFG_W-1:0]          cfg_data
);

  import ffsd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic                  skid_full;
  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic [2*PIX_W-1:0]    ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  logic [2*PIX_W-1:0]    ram_rd_data;
  tap_t                  tap;

  assign cfg_ready = 1'b1;

  // Each entry holds {row above, centre row} for one column.
  ffsd_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ffsd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_value (pixel_value),
    .frame_start (frame_start),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .skid_full   (skid_full),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .tap         (tap)
  );

  ffsd_out u_out (
    .clk        (clk),
    .rst        (rst),
    .tap        (tap),
    .skid_full  (skid_full),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .heat_value (heat_value)
  );

endmodule

/* hw/rtl/ffsd_checker.sv */
// ----------------------------------------------------------------------------
// ffsd_checker
// Port-level checks of the fire field filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_row,
  input logic [7:0] out_col,
  input logic [7:0] heat_value
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable({out_row, out_col, heat_value}))
  `ASSERT_IMPL(a_heat_range, clk, rst, out_valid, heat_value != 8'd254 && heat_value != 8'd255)
  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

endmodule

bind fire_field_stencil_decay ffsd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_row    (out_row),
  .out_col    (out_col),
  .heat_value (heat_value)
);

/* verif/fire_field_stencil_decay_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_field_stencil_decay_test
// Streams coarse fire frames of several geometries into the stencil filter,
// predicts every averaged and decayed pixel from its own line buffers, and
// checks each result in order under random idling and a long output stall.
// ----------------------------------------------------------------------------
module fire_field_stencil_decay_test;
  import ffsd_pkg::*;

  localparam int MAX_W          = 256;
  localparam int ROW_WRAP       = 1 << ROW_W;
  localparam int IDLE_PCT       = 26;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fs;
  } pixel_req_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] heat;
  } heat_req_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] pixel_value = '0;
  logic             frame_start = 1'b0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] heat_value;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  cfg_idx_t         cfg_index   = REG_LINE_WIDTH;
  logic [CFG_W-1:0] cfg_data    = '0;

  logic             calm        = 1'b0;
  logic             hold_arm    = 1'b0;
  bit               hold_done   = 1'b0;
  int unsigned      hold_left   = 0;
  int unsigned      quiet_cycles = 0;

  pixel_req_t  pixel_queue[$];
  heat_req_t   heat_expected[$];
  heat_req_t   oldest_heat;
  pixel_req_t  head_req;
  int unsigned pixels_issued   = 0;
  int unsigned pixels_accepted = 0;
  int unsigned mismatch_count  = 0;

  logic [LW_W-1:0] geom_width;
  logic [FR_W-1:0] geom_rows;

  logic [PIX_W-1:0] upper_row  [MAX_W];
  logic [PIX_W-1:0] centre_row [MAX_W];
  logic [LW_W-1:0]  width_reg;
  logic [FR_W-1:0]  rows_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;

  fire_field_stencil_decay #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_value(pixel_value),
    .frame_start(frame_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_row    (out_row),
    .out_col    (out_col),
    .heat_value (heat_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned clamp_width(input logic [LW_W-1:0] w);
    if (w < WIDTH_MIN) return WIDTH_MIN;
    if (w > MAX_W) return MAX_W;
    return 32'(w);
  endfunction

  function automatic int unsigned clamp_rows(input logic [FR_W-1:0] r);
    if (r < ROWS_MIN) return 32'(ROWS_MIN);
    if (r > ROWS_MAX) return 32'(ROWS_MAX);
    return 32'(r);
  endfunction

  task automatic predict_heat(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned w;
    int unsigned r;
    int unsigned c;
    int unsigned sum;
    heat_req_t   e;
    w = clamp_width(width_reg);
    r = clamp_rows(rows_reg);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    c = col_pos;
    if (row_pos >= ROW_LAG && row_pos < r && c >= 1 && c + 3 <= w) begin
      sum = 32'(upper_row[c-1]);
      sum += 32'(centre_row[c]);
      sum += 32'(centre_row[c+1]);
      sum += 32'(pix);
      sum = sum >> 2;
      sum = (sum + 32'(upper_row[c])) >> 1;
      if (sum > DECAY_HIGH) sum -= 2;
      else if (sum > DECAY_MID) sum -= 4;
      else if (sum > DECAY_LOW) sum -= 2;
      else if (sum > 0) sum -= 1;
      e.row  = ROW_W'(row_pos - ROW_LAG);
      e.col  = COL_W'(c);
      e.heat = PIX_W'(sum);
      heat_expected.push_back(e);
    end
    upper_row[c]  = centre_row[c];
    centre_row[c] = pix;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % ROW_WRAP;
    end
  endtask

  // Pixel driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        head_req = pixel_queue.pop_front();
        in_valid    <= 1'b1;
        pixel_value <= head_req.pix;
        frame_start <= head_req.fs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: track config and pixel requests, check results
  always @(posedge clk) begin
    if (rst) begin
      width_reg = WIDTH_RESET;
      rows_reg  = ROWS_RESET;
      col_pos   = 0;
      row_pos   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LINE_WIDTH: width_reg = cfg_data[LW_W-1:0];
          REG_FRAME_ROWS: rows_reg = cfg_data[FR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_heat(pixel_value, frame_start);
        pixels_accepted++;
      end
      if (out_valid && out_ready) begin
        if (heat_expected.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("unexpected result: row %0d col %0d heat %0d",
                     out_row, out_col, heat_value);
          mismatch_count++;
        end else begin
          oldest_heat = heat_expected.pop_front();
          if (out_row !== oldest_heat.row || out_col !== oldest_heat.col ||
              heat_value !== oldest_heat.heat) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("mismatch: exp row %0d col %0d heat %0d, got row %0d col %0d heat %0d",
                       oldest_heat.row, oldest_heat.col, oldest_heat.heat,
                       out_row, out_col, heat_value);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** fire_field_stencil_decay: FAILED **");
        $finish;
      end
    end
  end

  task automatic queue_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    pixel_queue.push_back('{pix: pix, fs: fs});
    pixels_issued++;
  endtask

  task automatic drain_block();
    while (pixels_accepted != pixels_issued || heat_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input logic [LW_W-1:0] w, input logic [FR_W-1:0] r);
    drain_block();
    write_reg(REG_LINE_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_ROWS, CFG_W'(r));
    geom_width = w;
    geom_rows  = r;
  endtask

  function automatic logic [PIX_W-1:0] pick_heat(input int unsigned mode,
                                                 input logic [PIX_W-1:0] level);
    case (mode)
      0: return PIX_W'($urandom_range(255));
      1: return PIX_W'($urandom_range(15));
      2: return $urandom_range(1) ? 8'hFF : 8'h00;
      3: return level ^ PIX_W'($urandom_range(3));
      default: return level;
    endcase
  endfunction

  task automatic queue_frames(input int n_items);
    int unsigned      w;
    int unsigned      r;
    int unsigned      len;
    int unsigned      k;
    int unsigned      mode;
    logic [PIX_W-1:0] level;
    int               left;
    bit               first;
    w = clamp_width(geom_width);
    r = clamp_rows(geom_rows);
    left  = n_items;
    first = 1'b1;
    while (left > 0) begin
      len = w * r;
      case ($urandom_range(9))
        0, 1: len = $urandom_range(w * r - 1, 1);
        2: len = w * r + $urandom_range(2 * w, 1);
        default: ;
      endcase
      mode  = $urandom_range(4);
      level = PIX_W'($urandom_range(255));
      for (k = 0; k < len && left > 0; k++) begin
        queue_pixel(pick_heat(mode, level), (k == 0) && (first || $urandom_range(9) != 0));
        left--;
      end
      first = 1'b0;
    end
  endtask

  initial begin
    int unsigned k;
    int          n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // smallest frame: saturated heat, then a raster jump off column zero
    set_geometry(LW_W'(WIDTH_MIN), ROWS_MIN);
    for (k = 0; k < 16; k++) queue_pixel(8'hFF, k == 0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h00, 1'b0);
    queue_pixel(8'h00, 1'b1);
    queue_pixel(8'h00, 1'b0);

    set_geometry(9'd6, 11'd7);
    calm <= 1'b1;
    queue_frames(200);
    drain_block();
    calm <= 1'b0;

    // undersized registers; run well past the end of the frame
    set_geometry(9'd0, 11'd2);
    queue_pixel(PIX_W'($urandom_range(255)), 1'b1);
    for (k = 1; k < 4 * 30; k++) queue_pixel(PIX_W'($urandom_range(255)), 1'b0);

    // oversized width: full-width rows into the fourth row
    set_geometry(9'd511, 11'd0);
    queue_pixel(PIX_W'($urandom_range(255)), 1'b1);
    for (k = 1; k < 3 * MAX_W + 64; k++) queue_pixel(PIX_W'($urandom_range(255)), 1'b0);

    // oversized rows; hold the sink while pixels keep coming
    set_geometry(9'd9, 11'd2047);
    queue_frames(300);
    hold_arm <= 1'b1;

    set_geometry(9'd256, ROWS_MAX);
    queue_frames(40);

    for (n = 0; n < 3; n++) begin
      set_geometry(LW_W'($urandom_range(24, 4)), FR_W'($urandom_range(12, 4)));
      queue_frames(100);
    end

    set_geometry(LW_W'(WIDTH_MIN), ROWS_MIN);
    queue_frames(60);

    drain_block();
    if (mismatch_count == 0 && heat_expected.size() == 0) begin
      $display("** fire_field_stencil_decay: PASSED **");
    end else begin
      $display("** fire_field_stencil_decay: FAILED **");
    end
    $finish;
  end

endmodule
